/* src/convex_quad_overlap_test_assert.svh */
// Assertion macros shared by the convex quad overlap test RTL.
// Depends on nothing; included by the top level.
`ifndef CONVEX_QUAD_OVERLAP_TEST_ASSERT_SVH
`define CONVEX_QUAD_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CQOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cqot assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CQOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cqot assertion failed");

`endif

/* src/cqot_pkg.sv */
// Package for the convex quad overlap test: transaction structs, lane control
// struct and shared constants. Depends on nothing.
`default_nettype none

package cqot_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int HALF_BITS       = 16;
    localparam int NUM_CORNERS     = 4;
    localparam int NUM_QUAD_TESTS  = 2 * NUM_CORNERS;
    localparam int NUM_EDGE_LANES  = NUM_QUAD_TESTS * NUM_CORNERS;
    localparam int NUM_SEG_LANES   = 3;

    localparam int SEG_DEN = 0;
    localparam int SEG_N1  = 1;
    localparam int SEG_N2  = 2;

    typedef struct packed {
        logic [2*HALF_BITS-1:0] first_corner_a;
        logic [2*HALF_BITS-1:0] first_corner_b;
        logic [2*HALF_BITS-1:0] first_corner_c;
        logic [2*HALF_BITS-1:0] first_corner_d;
        logic [2*HALF_BITS-1:0] second_corner_a;
        logic [2*HALF_BITS-1:0] second_corner_b;
        logic [2*HALF_BITS-1:0] second_corner_c;
        logic [2*HALF_BITS-1:0] second_corner_d;
    } cqot_in_t;

    typedef struct packed {
        logic                      overlap;
        logic [NUM_QUAD_TESTS-1:0] corner_hit_mask;
        logic                      edge_cross;
    } cqot_out_t;

    typedef struct packed {
        logic diff;
        logic prod;
        logic xprod;
    } cqot_adv_t;

endpackage

`default_nettype wire

/* src/cqot_cross_lane.sv */
// One cross product lane: registered edge vectors, products and difference.
// Depends on cqot_pkg for the stage advance struct.
`default_nettype none

module cqot_cross_lane #(
    parameter int EFF_WIDTH = 16
) (
    input  wire                               aclk,
    input  wire cqot_pkg::cqot_adv_t          adv,
    input  wire logic signed [EFF_WIDTH-1:0]  ua_x,
    input  wire logic signed [EFF_WIDTH-1:0]  ua_y,
    input  wire logic signed [EFF_WIDTH-1:0]  ub_x,
    input  wire logic signed [EFF_WIDTH-1:0]  ub_y,
    input  wire logic signed [EFF_WIDTH-1:0]  va_x,
    input  wire logic signed [EFF_WIDTH-1:0]  va_y,
    input  wire logic signed [EFF_WIDTH-1:0]  vb_x,
    input  wire logic signed [EFF_WIDTH-1:0]  vb_y,
    output logic signed [2*EFF_WIDTH+2:0]     cross_o
);
    import cqot_pkg::*;

    localparam int DW = EFF_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg;
    logic signed [PW:0]   cross_reg;

    always_ff @(posedge aclk) begin
        if (adv.diff) begin
            ux_reg <= {ub_x[EFF_WIDTH-1], ub_x} - {ua_x[EFF_WIDTH-1], ua_x};
            uy_reg <= {ub_y[EFF_WIDTH-1], ub_y} - {ua_y[EFF_WIDTH-1], ua_y};
            vx_reg <= {vb_x[EFF_WIDTH-1], vb_x} - {va_x[EFF_WIDTH-1], va_x};
            vy_reg <= {vb_y[EFF_WIDTH-1], vb_y} - {va_y[EFF_WIDTH-1], va_y};
        end
        if (adv.prod) begin
            p0_reg <= ux_reg * vy_reg;
            p1_reg <= uy_reg * vx_reg;
        end
        if (adv.xprod) begin
            cross_reg <= {p0_reg[PW-1], p0_reg} - {p1_reg[PW-1], p1_reg};
        end
    end

    assign cross_o = cross_reg;

endmodule

`default_nettype wire

/* src/cqot_merge.sv */
// Merge stage: folds the lane cross products into the corner mask, the
// segment crossing flag and the overlap flag. Depends on cqot_pkg.
`default_nettype none

module cqot_merge #(
    parameter int EFF_WIDTH = 16
) (
    input  wire logic signed [2*EFF_WIDTH+2:0] edge_x [cqot_pkg::NUM_EDGE_LANES],
    input  wire logic signed [2*EFF_WIDTH+2:0] seg_x  [cqot_pkg::NUM_SEG_LANES],
    output cqot_pkg::cqot_out_t                out_o
);
    import cqot_pkg::*;

    localparam int XW = 2 * EFF_WIDTH + 3;

    logic [NUM_CORNERS-1:0]    neg_w [NUM_QUAD_TESTS];
    logic [NUM_QUAD_TESTS-1:0] mask_w;
    logic                      cross_w;

    function automatic logic param_ok(input logic signed [XW-1:0] num,
                                      input logic signed [XW-1:0] den);
        logic ok;
        if (den == '0) begin
            ok = (num == '0);
        end else if (!den[XW-1]) begin
            ok = !num[XW-1] && (num <= den);
        end else begin
            ok = (num[XW-1] || num == '0) && (num >= den);
        end
        return ok;
    endfunction

    for (genvar t = 0; t < NUM_QUAD_TESTS; t++) begin : g_test
        for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
            assign neg_w[t][e] = edge_x[t*NUM_CORNERS+e][XW-1];
        end
        assign mask_w[t] = ~|neg_w[t];
    end

    assign cross_w = param_ok(seg_x[SEG_N1], seg_x[SEG_DEN])
                  && param_ok(seg_x[SEG_N2], seg_x[SEG_DEN]);

    always_comb begin
        out_o.overlap         = (|mask_w) || cross_w;
        out_o.corner_hit_mask = mask_w;
        out_o.edge_cross      = cross_w;
    end

endmodule

`default_nettype wire

/* src/convex_quad_overlap_test.sv */
// Top level of the convex quad overlap test: handshake, stage control,
// corner unpacking, 35 cross product lanes and the merge stage.
// Depends on cqot_pkg, cqot_cross_lane, cqot_merge and the assertion header.
//
//  Channel  Direction  Handshake          Transaction
//  s_       in         s_valid / s_ready  cqot_in_t: two quads, four corners each
//  m_       out        m_valid / m_ready  cqot_out_t: overlap, corner mask, crossing
//
// One transaction per cycle is accepted and one result per cycle delivered
// while m_ready is high. A result passes through the input register, edge
// vector register, product register, cross product register, then the merged
// output register. Reset is synchronous and empties every stage. A stall on
// m_ready holds only the stages behind a full one; bubbles are squeezed out.
`default_nettype none
`include "convex_quad_overlap_test_assert.svh"

module convex_quad_overlap_test #(
    parameter int COORD_WIDTH = cqot_pkg::COORD_WIDTH_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire cqot_pkg::cqot_in_t    s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output cqot_pkg::cqot_out_t        m_data
);
    import cqot_pkg::*;

    localparam int EW = (COORD_WIDTH < HALF_BITS) ? COORD_WIDTH : HALF_BITS;
    localparam int XW = 2 * EW + 3;

    cqot_in_t  in_reg;
    cqot_out_t out_reg;
    cqot_out_t merge_w;
    logic      in_valid_reg, diff_valid_reg, prod_valid_reg, cross_valid_reg, out_valid_reg;
    logic      free_in, free_diff, free_prod, free_cross, free_out;
    cqot_adv_t adv;

    logic [2*HALF_BITS-1:0] corner_w [NUM_QUAD_TESTS];
    logic signed [EW-1:0]   pt_x [NUM_QUAD_TESTS];
    logic signed [EW-1:0]   pt_y [NUM_QUAD_TESTS];
    logic signed [XW-1:0]   edge_x [NUM_EDGE_LANES];
    logic signed [XW-1:0]   seg_x  [NUM_SEG_LANES];

    assign free_out   = !out_valid_reg || m_ready;
    assign free_cross = !cross_valid_reg || free_out;
    assign free_prod  = !prod_valid_reg || free_cross;
    assign free_diff  = !diff_valid_reg || free_prod;
    assign free_in    = !in_valid_reg || free_diff;

    assign s_ready   = free_in;
    assign adv.diff  = free_diff;
    assign adv.prod  = free_prod;
    assign adv.xprod = free_cross;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            diff_valid_reg  <= 1'b0;
            prod_valid_reg  <= 1'b0;
            cross_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (free_in) begin
                in_valid_reg <= s_valid;
            end
            if (free_diff) begin
                diff_valid_reg <= in_valid_reg;
            end
            if (free_prod) begin
                prod_valid_reg <= diff_valid_reg;
            end
            if (free_cross) begin
                cross_valid_reg <= prod_valid_reg;
            end
            if (free_out) begin
                out_valid_reg <= cross_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free_in) begin
            in_reg <= s_data;
        end
        if (free_out) begin
            out_reg <= merge_w;
        end
    end

    assign corner_w[0] = in_reg.first_corner_a;
    assign corner_w[1] = in_reg.first_corner_b;
    assign corner_w[2] = in_reg.first_corner_c;
    assign corner_w[3] = in_reg.first_corner_d;
    assign corner_w[4] = in_reg.second_corner_a;
    assign corner_w[5] = in_reg.second_corner_b;
    assign corner_w[6] = in_reg.second_corner_c;
    assign corner_w[7] = in_reg.second_corner_d;

    for (genvar i = 0; i < NUM_QUAD_TESTS; i++) begin : g_unpack
        assign pt_x[i] = corner_w[i][EW-1:0];
        assign pt_y[i] = corner_w[i][HALF_BITS+EW-1:HALF_BITS];
    end

    // Tests 0-3 place second-quad corners against the first quad's edges,
    // tests 4-7 place first-quad corners against the second quad's edges.
    for (genvar t = 0; t < NUM_QUAD_TESTS; t++) begin : g_test
        localparam int QB = (t < NUM_CORNERS) ? 0 : NUM_CORNERS;
        localparam int PI = (t < NUM_CORNERS) ? t + NUM_CORNERS : t - NUM_CORNERS;
        for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
            localparam int EA = QB + e;
            localparam int EB = QB + ((e + 1) % NUM_CORNERS);
            cqot_cross_lane #(
                .EFF_WIDTH(EW)
            ) u_lane (
                .aclk    (aclk),
                .adv     (adv),
                .ua_x    (pt_x[EA]),
                .ua_y    (pt_y[EA]),
                .ub_x    (pt_x[EB]),
                .ub_y    (pt_y[EB]),
                .va_x    (pt_x[EB]),
                .va_y    (pt_y[EB]),
                .vb_x    (pt_x[PI]),
                .vb_y    (pt_y[PI]),
                .cross_o (edge_x[t*NUM_CORNERS+e])
            );
        end
    end

    // Segment d1->a1 against c2->d2: denominator and the two numerators.
    cqot_cross_lane #(
        .EFF_WIDTH(EW)
    ) u_seg_den (
        .aclk    (aclk),
        .adv     (adv),
        .ua_x    (pt_x[3]),
        .ua_y    (pt_y[3]),
        .ub_x    (pt_x[0]),
        .ub_y    (pt_y[0]),
        .va_x    (pt_x[6]),
        .va_y    (pt_y[6]),
        .vb_x    (pt_x[7]),
        .vb_y    (pt_y[7]),
        .cross_o (seg_x[SEG_DEN])
    );

    cqot_cross_lane #(
        .EFF_WIDTH(EW)
    ) u_seg_n1 (
        .aclk    (aclk),
        .adv     (adv),
        .ua_x    (pt_x[6]),
        .ua_y    (pt_y[6]),
        .ub_x    (pt_x[7]),
        .ub_y    (pt_y[7]),
        .va_x    (pt_x[6]),
        .va_y    (pt_y[6]),
        .vb_x    (pt_x[3]),
        .vb_y    (pt_y[3]),
        .cross_o (seg_x[SEG_N1])
    );

    cqot_cross_lane #(
        .EFF_WIDTH(EW)
    ) u_seg_n2 (
        .aclk    (aclk),
        .adv     (adv),
        .ua_x    (pt_x[3]),
        .ua_y    (pt_y[3]),
        .ub_x    (pt_x[0]),
        .ub_y    (pt_y[0]),
        .va_x    (pt_x[6]),
        .va_y    (pt_y[6]),
        .vb_x    (pt_x[3]),
        .vb_y    (pt_y[3]),
        .cross_o (seg_x[SEG_N2])
    );

    cqot_merge #(
        .EFF_WIDTH(EW)
    ) u_merge (
        .edge_x (edge_x),
        .seg_x  (seg_x),
        .out_o  (merge_w)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `CQOT_ASSERT_NOW(a_overlap_consistent, aclk, aresetn, m_valid,
        m_data.overlap == ((|m_data.corner_hit_mask) || m_data.edge_cross))
    `CQOT_ASSERT_NEXT(a_cross_stage_kept, aclk, aresetn,
        cross_valid_reg && out_valid_reg && !m_ready, cross_valid_reg)
    `CQOT_ASSERT_NEXT(a_input_stage_held, aclk, aresetn,
        in_valid_reg && !s_ready, in_valid_reg && $stable(in_reg))

endmodule

`default_nettype wire
